/* src/sfas_pkg.sv */
// Shared types and constants for the sprite frame animation sequencer.
// Used by sfas_cfg, sfas_ctrl, sfas_dp and the top level; no dependencies.
`default_nettype none

package sfas_pkg;

	// Fixed field widths
	localparam int ELAPSED_W  = 16;
	localparam int SPEED_W    = 16;
	localparam int PROD_W     = ELAPSED_W + SPEED_W;
	localparam int SPEED_FRAC = 8;
	localparam int TOTAL_W    = 9;
	localparam int FT_W       = 24;
	localparam int MODE_W     = 2;
	localparam int HOLD_W     = 24;
	localparam int BASE_W     = 16;
	localparam int INDEX_W    = 17;
	localparam int FNUM_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Advances in one tick before the remaining count is folded by the period
	localparam int SETTLE_W = 10;
	localparam logic [SETTLE_W-1:0] SETTLE_STEPS = 10'd600;

	typedef logic [MODE_W-1:0] mode_t;
	localparam mode_t MODE_LOOP     = 2'd0;
	localparam mode_t MODE_PINGPONG = 2'd1;
	localparam mode_t MODE_ONCE     = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOTAL_FRAMES = 3'd0,
		REG_FRAME_TIME   = 3'd1,
		REG_SPEED        = 3'd2,
		REG_LOOP_MODE    = 3'd3,
		REG_END_HOLD     = 3'd4,
		REG_BASE_COLUMN  = 3'd5
	} reg_idx_t;

	localparam logic [TOTAL_W-1:0] TOTAL_RST = 9'd1;
	localparam logic [SPEED_W-1:0] SPEED_RST = 16'd256;

	typedef struct packed {
		logic [TOTAL_W-1:0] total_frames;
		logic [FT_W-1:0]    frame_time;
		logic [SPEED_W-1:0] speed_factor;
		mode_t              loop_mode;
		logic [HOLD_W-1:0]  end_hold_time;
		logic [BASE_W-1:0]  base_column;
	} cfg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_STEP,
		S_DIV,
		S_SPLIT,
		S_MOVE,
		S_RED,
		S_RSPLIT,
		S_MUL,
		S_WB,
		S_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic hold_dec;
		logic acc_add;
		logic div_step;
		logic split;
		logic red_load;
		logic rsplit;
		logic move;
		logic mul_step;
		logic writeback;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic hold_busy;
		logic cnt_last;
		logic n_zero;
		logic settle;
		logic mv_stop;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

/* src/sfas_cfg.sv */
// Configuration register bank of the animation sequencer.
// Depends on sfas_pkg for the register index codes and the cfg_t bundle.
`default_nettype none

module sfas_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [sfas_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sfas_pkg::CFG_DATA_W-1:0]   cfg_data,
	output sfas_pkg::cfg_t                    cfg
);
	import sfas_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.total_frames  <= TOTAL_RST;
			cfg_q.frame_time    <= '0;
			cfg_q.speed_factor  <= SPEED_RST;
			cfg_q.loop_mode     <= MODE_LOOP;
			cfg_q.end_hold_time <= '0;
			cfg_q.base_column   <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_TOTAL_FRAMES: cfg_q.total_frames  <= cfg_data[TOTAL_W-1:0];
				REG_FRAME_TIME:   cfg_q.frame_time    <= cfg_data[FT_W-1:0];
				REG_SPEED:        cfg_q.speed_factor  <= cfg_data[SPEED_W-1:0];
				REG_LOOP_MODE:    cfg_q.loop_mode     <= cfg_data[MODE_W-1:0];
				REG_END_HOLD:     cfg_q.end_hold_time <= cfg_data[HOLD_W-1:0];
				REG_BASE_COLUMN:  cfg_q.base_column   <= cfg_data[BASE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* src/sfas_ctrl.sv */
// Sequencing state machine of the animation sequencer.
// Depends on sfas_pkg (state_t, cmd_t, sts_t); drives sfas_dp by commands only.
`default_nettype none

module sfas_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           tick_valid,
	output logic           tick_stall,
	input  sfas_pkg::sts_t sts,
	output sfas_pkg::cmd_t cmd
);
	import sfas_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (tick_valid) state_d = S_STEP;
			end
			S_STEP: begin
				if (sts.skip || sts.hold_busy) state_d = S_OUT;
				else state_d = S_DIV;
			end
			S_DIV: begin
				if (sts.cnt_last) state_d = S_SPLIT;
			end
			S_SPLIT: state_d = S_MOVE;
			S_MOVE: begin
				if (sts.n_zero) state_d = S_WB;
				else if (sts.settle) state_d = S_RED;
				else if (sts.mv_stop) state_d = S_MUL;
			end
			S_RED: begin
				if (sts.cnt_last) state_d = S_RSPLIT;
			end
			S_RSPLIT: state_d = S_MOVE;
			S_MUL: begin
				if (sts.cnt_last) state_d = S_WB;
			end
			S_WB: state_d = S_OUT;
			S_OUT: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		tick_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				tick_stall  = 1'b0;
				cmd.capture = tick_valid;
			end
			S_STEP: begin
				if (!sts.skip) begin
					if (sts.hold_busy) cmd.hold_dec = 1'b1;
					else cmd.acc_add = 1'b1;
				end
			end
			S_DIV:    cmd.div_step = 1'b1;
			S_SPLIT:  cmd.split = 1'b1;
			S_MOVE: begin
				if (!sts.n_zero) begin
					if (sts.settle) cmd.red_load = 1'b1;
					else cmd.move = 1'b1;
				end
			end
			S_RED:    cmd.div_step = 1'b1;
			S_RSPLIT: cmd.rsplit = 1'b1;
			S_MUL:    cmd.mul_step = 1'b1;
			S_WB:     cmd.writeback = 1'b1;
			S_OUT:    cmd.out_load = sts.out_free;
			default: begin
			end
		endcase
	end

	// at most one datapath operation per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("sfas_ctrl: more than one command in a cycle");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && !tick_stall |=> state_q == S_STEP)
		else $error("sfas_ctrl: accepted tick did not start processing");

	// a finished result is never dropped while the output is blocked
	a_out_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && !sts.out_free |=> state_q == S_OUT && !cmd.capture)
		else $error("sfas_ctrl: left result state with output blocked");

endmodule

`default_nettype wire

/* src/sfas_dp.sv */
// Datapath of the animation sequencer: speed scaling, hold and accumulator,
// shared shift-subtract divider, frame stepper, shift-add multiplier, result register.
// Depends on sfas_pkg; every operation is started by a command from sfas_ctrl.
`default_nettype none

module sfas_dp #(
	parameter int FRAME_BITS = 8,
	parameter int TIME_BITS  = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sfas_pkg::cfg_t                   cfg,
	input  sfas_pkg::cmd_t                   cmd,
	output sfas_pkg::sts_t                   sts,
	input  logic [sfas_pkg::ELAPSED_W-1:0]   elapsed,
	input  logic                             res_stall,
	output logic                             res_valid,
	output logic [sfas_pkg::INDEX_W-1:0]     sprite_index,
	output logic [sfas_pkg::FNUM_W-1:0]      frame_number,
	output logic                             done_res
);
	import sfas_pkg::*;

	localparam int ACC_W  = TIME_BITS + 1;
	localparam int CNT_W  = $clog2(ACC_W);
	localparam int WIDE_W = (TIME_BITS > FT_W) ? TIME_BITS : FT_W;
	localparam int TOT_W  = (FRAME_BITS + 1 > TOTAL_W) ? FRAME_BITS + 1 : TOTAL_W;
	localparam int FW1    = FRAME_BITS + 1;
	localparam int MW     = ((ACC_W > FT_W) ? ACC_W : FT_W) + 1;
	localparam int FLIM   = 1 << FRAME_BITS;
	localparam logic [WIDE_W-1:0] TMAX_WIDE = WIDE_W'({TIME_BITS{1'b1}});

	// animation state
	logic [FRAME_BITS-1:0] frame_q;
	logic                  back_q;
	logic                  ended_q;
	logic [TIME_BITS-1:0]  hold_q;
	logic [ACC_W-1:0]      acc_q;

	// working registers of one tick
	logic [PROD_W-1:0]     prod_q;
	logic [ACC_W-1:0]      dq_q;
	logic [FT_W-1:0]       dr_q;
	logic [FT_W-1:0]       dvs_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [ACC_W-1:0]      n_q;
	logic [FT_W-1:0]       rem_q;
	logic [SETTLE_W-1:0]   moves_q;
	logic                  reduced_q;
	logic [ACC_W-1:0]      p_q;

	// result register
	logic                  res_valid_q;
	logic [INDEX_W-1:0]    sprite_index_q;
	logic [FNUM_W-1:0]     frame_number_q;
	logic                  done_res_q;

	logic [WIDE_W-1:0]     step_wide;
	logic [TIME_BITS-1:0]  step;
	logic [WIDE_W-1:0]     eht_wide;
	logic [TIME_BITS-1:0]  hold_load;
	logic                  eht_nz;
	logic [TOT_W-1:0]      tot_w;
	logic [TOT_W-1:0]      tot_c;
	logic [TOT_W-1:0]      last_w;
	logic [FRAME_BITS-1:0] last;
	logic                  multi;
	logic [ACC_W:0]        acc_sum;
	logic [ACC_W-1:0]      acc_sat;
	logic [FT_W:0]         trial;
	logic [FT_W:0]         div_diff;
	logic                  div_ge;
	logic [FT_W-1:0]       div_rem;
	logic [FW1-1:0]        f1;
	logic [FW1-1:0]        last1;
	logic [FW1-1:0]        period;
	logic [FRAME_BITS-1:0] mv_frame;
	logic                  mv_back;
	logic                  mv_ended;
	logic                  mv_end;
	logic [MW-1:0]         mul_sum;
	logic [MW-1:0]         wb_sum;

	// Q8.8 scaling, fraction dropped, saturated to the time width
	assign step_wide = WIDE_W'(prod_q >> SPEED_FRAC);
	assign step      = (step_wide > TMAX_WIDE) ? '1 : step_wide[TIME_BITS-1:0];
	assign eht_wide  = WIDE_W'(cfg.end_hold_time);
	assign hold_load = (eht_wide > TMAX_WIDE) ? '1 : eht_wide[TIME_BITS-1:0];
	assign eht_nz    = cfg.end_hold_time != '0;

	assign tot_w  = TOT_W'(cfg.total_frames);
	assign tot_c  = (tot_w > TOT_W'(FLIM)) ? TOT_W'(FLIM) : tot_w;
	assign last_w = tot_c - TOT_W'(1);
	assign last   = last_w[FRAME_BITS-1:0];
	assign multi  = tot_c > TOT_W'(1);

	assign acc_sum = (ACC_W+1)'(acc_q) + (ACC_W+1)'(step);
	assign acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

	// one quotient bit per cycle
	assign trial    = {dr_q, dq_q[ACC_W-1]};
	assign div_ge   = trial >= {1'b0, dvs_q};
	assign div_diff = trial - {1'b0, dvs_q};
	assign div_rem  = div_ge ? div_diff[FT_W-1:0] : trial[FT_W-1:0];

	// Horner form: partial products never exceed the final one, which fits the accumulator
	assign mul_sum = (MW'(p_q) << 1) + (n_q[ACC_W-1] ? MW'(cfg.frame_time) : MW'(0));
	assign wb_sum  = MW'(p_q) + MW'(rem_q);

	assign f1    = FW1'(frame_q) + FW1'(1);
	assign last1 = FW1'(last);

	always_comb begin
		mv_frame = frame_q;
		mv_back  = back_q;
		mv_ended = ended_q;
		mv_end   = 1'b0;
		case (cfg.loop_mode)
			MODE_LOOP: begin
				if (f1 > last1) begin
					mv_end   = 1'b1;
					mv_frame = '0;
				end else begin
					mv_frame = f1[FRAME_BITS-1:0];
				end
			end
			MODE_PINGPONG: begin
				if (back_q) begin
					if (frame_q <= FRAME_BITS'(1)) begin
						mv_end   = 1'b1;
						mv_frame = '0;
						mv_back  = 1'b0;
					end else begin
						mv_frame = frame_q - FRAME_BITS'(1);
					end
				end else begin
					if (f1 >= last1) begin
						mv_end   = 1'b1;
						mv_frame = last;
						mv_back  = 1'b1;
					end else begin
						mv_frame = f1[FRAME_BITS-1:0];
					end
				end
			end
			MODE_ONCE: begin
				if (f1 >= last1) begin
					mv_end   = 1'b1;
					mv_frame = last;
					mv_ended = 1'b1;
				end else begin
					mv_frame = f1[FRAME_BITS-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// number of advances after which the frame state repeats
	always_comb begin
		case (cfg.loop_mode)
			MODE_LOOP:     period = last1 + FW1'(1);
			MODE_PINGPONG: period = {last, 1'b0};
			default:       period = FW1'(1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			back_q  <= 1'b0;
			ended_q <= 1'b0;
			hold_q  <= '0;
			acc_q   <= '0;
		end else begin
			if (cmd.hold_dec) hold_q <= hold_q - step;
			if (cmd.acc_add) hold_q <= '0;
			if (cmd.move) begin
				frame_q <= mv_frame;
				back_q  <= mv_back;
				ended_q <= mv_ended;
				if (mv_end && eht_nz) hold_q <= hold_load;
			end
			if (cmd.writeback) acc_q <= wb_sum[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) prod_q <= PROD_W'(elapsed) * PROD_W'(cfg.speed_factor);
		if (cmd.acc_add) begin
			dq_q  <= acc_sat;
			dr_q  <= '0;
			dvs_q <= cfg.frame_time;
			cnt_q <= '0;
		end
		if (cmd.red_load) begin
			dq_q  <= n_q;
			dr_q  <= '0;
			dvs_q <= FT_W'(period);
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			dq_q  <= {dq_q[ACC_W-2:0], div_ge};
			dr_q  <= div_rem;
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.split) begin
			n_q       <= dq_q;
			rem_q     <= dr_q;
			moves_q   <= '0;
			reduced_q <= 1'b0;
			p_q       <= '0;
			cnt_q     <= '0;
		end
		if (cmd.rsplit) begin
			// remainder is below the old count, so it fits the count width
			n_q       <= ACC_W'(dr_q);
			reduced_q <= 1'b1;
			p_q       <= '0;
			cnt_q     <= '0;
		end
		if (cmd.move) begin
			n_q <= n_q - ACC_W'(1);
			if (!reduced_q) moves_q <= moves_q + SETTLE_W'(1);
		end
		if (cmd.mul_step) begin
			p_q   <= mul_sum[ACC_W-1:0];
			n_q   <= {n_q[ACC_W-2:0], 1'b0};
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sprite_index_q <= INDEX_W'(cfg.base_column) + INDEX_W'(frame_q);
			frame_number_q <= FNUM_W'(frame_q);
			done_res_q     <= ended_q;
		end
	end

	assign sts.skip      = !multi || (cfg.frame_time == '0) || ended_q || (step == '0);
	assign sts.hold_busy = hold_q > step;
	assign sts.cnt_last  = cnt_q == CNT_W'(ACC_W - 1);
	assign sts.n_zero    = n_q == '0;
	assign sts.settle    = !reduced_q && (moves_q == SETTLE_STEPS);
	assign sts.mv_stop   = mv_end && (eht_nz || cfg.loop_mode == MODE_ONCE);
	assign sts.out_free  = !res_valid_q || !res_stall;

	assign res_valid    = res_valid_q;
	assign sprite_index = sprite_index_q;
	assign frame_number = frame_number_q;
	assign done_res     = done_res_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !res_valid_q || !res_stall)
		else $error("sfas_dp: result overwritten while stalled");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |=> dr_q < dvs_q)
		else $error("sfas_dp: partial remainder not below divisor");

	a_loop_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.move && cfg.loop_mode == MODE_LOOP |=> frame_q <= $past(last))
		else $error("sfas_dp: loop advance left the run");

endmodule

`default_nettype wire

/* src/sprite_frame_animation_sequencer.sv */
// Sprite frame animation sequencer, top level: register bank, controller and datapath.
// Depends on sfas_pkg, sfas_cfg, sfas_ctrl and sfas_dp.
//
// One tick transaction in gives one result transaction out. A tick that leaves the
// animation still (one frame or fewer, zero frame time, play-once finished, zero
// scaled step) or only counts down an end hold goes from the step state straight to
// the result state. A tick that advances first has the accumulator split into whole
// frame times by a shift-subtract divider at one quotient bit a cycle, then the
// frame stepper moves one frame a cycle. After 600 advances in one tick the
// remaining count is folded modulo the run's period by the same divider and
// stepping carries on. When an end hold or a play-once end stops stepping with
// whole frame times left, a shift-add multiply restores them to the accumulator.
// The block works on one tick at a time and takes the next tick in the cycle after
// the result is registered, while that result may still wait at the output.
`default_nettype none

module sprite_frame_animation_sequencer #(
	parameter int FRAME_BITS = 8,
	parameter int TIME_BITS  = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [sfas_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sfas_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             tick_valid,
	output logic                             tick_stall,
	input  logic [sfas_pkg::ELAPSED_W-1:0]   elapsed,
	output logic                             res_valid,
	input  logic                             res_stall,
	output logic [sfas_pkg::INDEX_W-1:0]     sprite_index,
	output logic [sfas_pkg::FNUM_W-1:0]      frame_number,
	output logic                             done_res
);
	import sfas_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	sfas_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfas_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	sfas_dp #(
		.FRAME_BITS (FRAME_BITS),
		.TIME_BITS  (TIME_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.elapsed      (elapsed),
		.res_stall    (res_stall),
		.res_valid    (res_valid),
		.sprite_index (sprite_index),
		.frame_number (frame_number),
		.done_res     (done_res)
	);

endmodule

`default_nettype wire

/* verif/sfas_checker.sv */
// Checker for the sprite frame animation sequencer: follows register writes, predicts each
// tick's result and compares it with what the block returns.
// Depends on sfas_pkg only.

module sfas_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [sfas_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sfas_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 tick_valid,
	input  logic                                 tick_stall,
	input  logic [sfas_pkg::ELAPSED_W-1:0]       elapsed,
	input  logic                                 res_valid,
	input  logic                                 res_stall,
	input  logic [sfas_pkg::INDEX_W-1:0]         sprite_index,
	input  logic [sfas_pkg::FNUM_W-1:0]          frame_number,
	input  logic                                 done_res,
	output int                                   fail_count,
	output int                                   outstanding
);
	import sfas_pkg::*;

	localparam int FRAME_BITS = 8;
	localparam int TIME_BITS  = 24;
	localparam longint unsigned FRAME_CAP  = 64'd1 << FRAME_BITS;
	localparam longint unsigned TIME_TOP   = (64'd1 << TIME_BITS) - 1;
	localparam longint unsigned ACC_TOP    = (64'd1 << (TIME_BITS + 1)) - 1;
	localparam longint unsigned FOLD_AFTER = 600;

	typedef struct packed {
		logic [INDEX_W-1:0] sprite_index;
		logic [FNUM_W-1:0]  frame_number;
		logic               done;
	} frame_res_t;

	cfg_t                  anim_cfg;
	logic [FRAME_BITS-1:0] cur_frame;
	logic                  reverse;
	logic                  finished;
	logic [TIME_BITS-1:0]  hold_left;
	logic [TIME_BITS:0]    time_acc;
	frame_res_t            expected_frames[$];

	// One frame move; returns 1 when a run end was reached.
	function automatic logic move_frame(input int unsigned last);
		int unsigned f;
		f = cur_frame;
		case (anim_cfg.loop_mode)
		MODE_LOOP: begin
			if (f + 1 > last) begin
				cur_frame = '0;
				return 1'b1;
			end
			cur_frame = FRAME_BITS'(f + 1);
			return 1'b0;
		end
		MODE_PINGPONG: begin
			if (reverse) begin
				if (f <= 1) begin
					cur_frame = '0;
					reverse = 1'b0;
					return 1'b1;
				end
				cur_frame = FRAME_BITS'(f - 1);
				return 1'b0;
			end
			if (f + 1 >= last) begin
				cur_frame = FRAME_BITS'(last);
				reverse = 1'b1;
				return 1'b1;
			end
			cur_frame = FRAME_BITS'(f + 1);
			return 1'b0;
		end
		MODE_ONCE: begin
			if (f + 1 >= last) begin
				cur_frame = FRAME_BITS'(last);
				finished = 1'b1;
				return 1'b1;
			end
			cur_frame = FRAME_BITS'(f + 1);
			return 1'b0;
		end
		default: return 1'b0;
		endcase
	endfunction

	// Applies one tick to the animation state and queues the result it should give.
	function automatic void advance_animation(input logic [ELAPSED_W-1:0] el);
		longint unsigned total, last, step, acc, n, remainder, moved, period, ft;
		logic            advancing, folded;
		frame_res_t      r;
		total = anim_cfg.total_frames;
		if (total > FRAME_CAP)
			total = FRAME_CAP;
		if (total > 1 && anim_cfg.frame_time != 0 && !finished) begin
			last = total - 1;
			step = el;
			step = (step * anim_cfg.speed_factor) >> SPEED_FRAC;
			if (step > TIME_TOP)
				step = TIME_TOP;
			advancing = (step != 0);
			if (advancing && hold_left != 0) begin
				if (hold_left > step) begin
					hold_left = hold_left - TIME_BITS'(step);
					advancing = 1'b0;
				end else begin
					hold_left = '0;
				end
			end
			if (advancing) begin
				ft = anim_cfg.frame_time;
				acc = time_acc + step;
				if (acc > ACC_TOP)
					acc = ACC_TOP;
				n = acc / ft;
				remainder = acc % ft;
				moved = 0;
				folded = 1'b0;
				case (anim_cfg.loop_mode)
				MODE_LOOP:     period = last + 1;
				MODE_PINGPONG: period = 2 * last;
				default:       period = 1;
				endcase
				while (n > 0) begin
					// long runs are folded by the cycle length once settled
					if (!folded && moved >= FOLD_AFTER && hold_left == 0) begin
						folded = 1'b1;
						n = n % period;
						if (n == 0)
							break;
					end
					n--;
					moved++;
					if (move_frame(last) && anim_cfg.end_hold_time != 0) begin
						hold_left = anim_cfg.end_hold_time;
						break;
					end
					if (finished)
						break;
				end
				// whole frame times not used stay in the accumulator
				time_acc = (TIME_BITS + 1)'(remainder + n * ft);
			end
		end
		r.sprite_index = INDEX_W'(anim_cfg.base_column) + INDEX_W'(cur_frame);
		r.frame_number = FNUM_W'(cur_frame);
		r.done = finished;
		expected_frames.push_back(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_res_t want;
		if (!arst_n) begin
			anim_cfg.total_frames = TOTAL_RST;
			anim_cfg.frame_time = '0;
			anim_cfg.speed_factor = SPEED_RST;
			anim_cfg.loop_mode = MODE_LOOP;
			anim_cfg.end_hold_time = '0;
			anim_cfg.base_column = '0;
			cur_frame = '0;
			reverse = 1'b0;
			finished = 1'b0;
			hold_left = '0;
			time_acc = '0;
			expected_frames.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (cfg_write) begin
				case (reg_idx_t'(cfg_index))
				REG_TOTAL_FRAMES: anim_cfg.total_frames = cfg_data[TOTAL_W-1:0];
				REG_FRAME_TIME:   anim_cfg.frame_time = cfg_data[FT_W-1:0];
				REG_SPEED:        anim_cfg.speed_factor = cfg_data[SPEED_W-1:0];
				REG_LOOP_MODE:    anim_cfg.loop_mode = cfg_data[MODE_W-1:0];
				REG_END_HOLD:     anim_cfg.end_hold_time = cfg_data[HOLD_W-1:0];
				REG_BASE_COLUMN:  anim_cfg.base_column = cfg_data[BASE_W-1:0];
				default: ;
				endcase
			end
			if (res_valid && !res_stall) begin
				if (expected_frames.size() == 0) begin
					$error("result transaction with no tick outstanding");
					fail_count++;
				end else begin
					want = expected_frames.pop_front();
					if (sprite_index !== want.sprite_index) begin
						$error("sprite_index: expected %0d, got %0d",
							want.sprite_index, sprite_index);
						fail_count++;
					end
					if (frame_number !== want.frame_number) begin
						$error("frame_number: expected %0d, got %0d",
							want.frame_number, frame_number);
						fail_count++;
					end
					if (done_res !== want.done) begin
						$error("done_res: expected %0d, got %0d", want.done, done_res);
						fail_count++;
					end
				end
			end
			if (tick_valid && !tick_stall)
				advance_animation(elapsed);
			outstanding = expected_frames.size();
		end
	end

endmodule

/* verif/tb_sprite_frame_animation_sequencer.sv */
// Testbench top for the sprite frame animation sequencer: clock, reset, register writes,
// tick stimulus with random idling on both channels, watchdog and verdict.
// Depends on sfas_pkg, sfas_checker and the block itself.

module tb_sprite_frame_animation_sequencer;
	import sfas_pkg::*;

	localparam mode_t MODE_UNUSED    = 2'd3;
	localparam int    RANDOM_TICKS   = 1300;
	// the limit covers the slowest tick (fold plus restore) plus both channels' bursts
	localparam int    WATCHDOG_LIMIT = 8000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  tick_valid = 1'b0;
	logic                  tick_stall;
	logic [ELAPSED_W-1:0]  elapsed = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	logic [INDEX_W-1:0]    sprite_index;
	logic [FNUM_W-1:0]     frame_number;
	logic                  done_res;

	int fail_count;
	int outstanding;
	bit send_gaps = 1'b0;
	bit recv_gaps = 1'b0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int ticks_sent = 0;
	int settings = 0;

	sprite_frame_animation_sequencer i_dut (.*);

	sfas_checker i_checker (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			res_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (recv_gaps && $urandom_range(0, 9) == 0) begin
			res_stall <= 1'b1;
			stall_left <= $urandom_range(0, 16);
		end else begin
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((tick_valid && !tick_stall) || (res_valid && !res_stall) || cfg_write) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [ELAPSED_W-1:0] rand_elapsed();
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		if (pick < 5)
			return ELAPSED_W'($urandom);
		return ELAPSED_W'($urandom_range(1, 3000));
	endfunction

	task automatic send_tick(input logic [ELAPSED_W-1:0] e);
		if (send_gaps && $urandom_range(0, 5) == 0) begin
			tick_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		tick_valid <= 1'b1;
		elapsed <= e;
		do @(posedge clk); while (tick_stall);
		@(negedge clk);
		ticks_sent++;
	endtask

	// Sender holds off until every outstanding tick has its result.
	task automatic drain();
		if (tick_valid)
			tick_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t r, input logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic load_settings(input logic [TOTAL_W-1:0] total, input logic [FT_W-1:0] ft,
			input logic [SPEED_W-1:0] speed, input mode_t mode,
			input logic [HOLD_W-1:0] hold, input logic [BASE_W-1:0] base);
		drain();
		write_reg(REG_TOTAL_FRAMES, CFG_DATA_W'(total));
		write_reg(REG_FRAME_TIME, CFG_DATA_W'(ft));
		write_reg(REG_SPEED, CFG_DATA_W'(speed));
		write_reg(REG_LOOP_MODE, CFG_DATA_W'(mode));
		write_reg(REG_END_HOLD, CFG_DATA_W'(hold));
		write_reg(REG_BASE_COLUMN, CFG_DATA_W'(base));
		settings++;
	endtask

	initial begin
		logic [TOTAL_W-1:0] r_total;
		logic [FT_W-1:0]    r_ft;
		logic [SPEED_W-1:0] r_speed;
		mode_t              r_mode;
		logic [HOLD_W-1:0]  r_hold;
		logic [BASE_W-1:0]  r_base;
		int                 random_left;
		int                 burst;
		int unsigned        pick;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: a single frame, nothing moves
		send_tick('1);
		send_tick('0);

		// loop wrap, zero step, fold of a long run, top base column
		load_settings(9'd4, 24'd100, SPEED_RST, MODE_LOOP, 24'd0, 16'hFFFF);
		send_tick(16'd0);
		send_tick(16'd100);
		send_tick(16'd250);
		send_tick(16'd1);
		send_tick('1);
		drain();
		write_reg(REG_SPEED, '0);
		send_tick(16'd500);
		drain();
		write_reg(REG_SPEED, 24'hFFFF);
		send_tick('1);

		// oversized frame count with the spare mode, then no frames at all
		load_settings(9'h1FF, 24'd1, SPEED_RST, MODE_UNUSED, 24'd0, 16'd0);
		send_tick(16'd700);
		drain();
		write_reg(REG_TOTAL_FRAMES, '0);
		send_tick(16'd300);

		// long loop, then shrink the run so the frame lies beyond it
		load_settings(9'd200, 24'd10, SPEED_RST, MODE_LOOP, 24'd0, 16'd77);
		send_tick(16'd1000);
		drain();
		write_reg(REG_TOTAL_FRAMES, 24'd4);
		write_reg(REG_LOOP_MODE, CFG_DATA_W'(MODE_PINGPONG));
		send_tick(16'd10);

		// ping-pong bouncing with an end hold
		load_settings(9'd5, 24'd10, SPEED_RST, MODE_PINGPONG, 24'd25, 16'd1234);
		send_tick(16'd30);
		send_tick(16'd50);
		send_tick(16'd10);
		send_tick(16'd20);
		send_tick(16'd40);
		send_tick(16'd200);
		drain();
		write_reg(REG_FRAME_TIME, '0);
		send_tick(16'd900);

		load_settings(9'd257, 24'hFFFFFF, SPEED_RST, MODE_LOOP, 24'hFFFFFF, 16'd0);
		send_tick('1);

		// random settings per phase; play-once is kept for the end as it never clears
		random_left = RANDOM_TICKS;
		while (random_left > 0) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				r_total = 9'd0;
			else if (pick == 1)
				r_total = 9'h1FF;
			else if (pick == 2)
				r_total = 9'd256;
			else if (pick < 5)
				r_total = TOTAL_W'($urandom_range(2, 256));
			else
				r_total = TOTAL_W'($urandom_range(2, 40));
			pick = $urandom_range(0, 24);
			if (pick == 0)
				r_ft = '0;
			else if (pick == 1)
				r_ft = 24'd1;
			else if (pick == 2)
				r_ft = '1;
			else
				r_ft = FT_W'($urandom_range(20, 3000));
			pick = $urandom_range(0, 24);
			if (pick == 0)
				r_speed = '0;
			else if (pick == 1)
				r_speed = '1;
			else
				r_speed = SPEED_W'($urandom_range(16, 1024));
			pick = $urandom_range(0, 9);
			if (pick < 5)
				r_mode = MODE_LOOP;
			else if (pick < 9)
				r_mode = MODE_PINGPONG;
			else
				r_mode = MODE_UNUSED;
			pick = $urandom_range(0, 24);
			if (pick < 12)
				r_hold = '0;
			else if (pick == 12)
				r_hold = '1;
			else
				r_hold = HOLD_W'($urandom_range(1, 5000));
			r_base = BASE_W'($urandom);
			load_settings(r_total, r_ft, r_speed, r_mode, r_hold, r_base);
			// no idling towards the end of the run
			send_gaps = (random_left > 200) && ($urandom_range(0, 3) != 0);
			recv_gaps = (random_left > 200) && ($urandom_range(0, 3) != 0);
			burst = $urandom_range(30, 70);
			repeat (burst) send_tick(rand_elapsed());
			random_left -= burst;
		end

		// clear any hold and empty the accumulator, then play once to the end
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		load_settings(9'd256, 24'hFFFFFF, 16'hFFFF, MODE_LOOP, 24'd0, BASE_W'($urandom));
		send_tick('1);
		send_tick('1);
		drain();
		write_reg(REG_FRAME_TIME, 24'd1);
		write_reg(REG_SPEED, CFG_DATA_W'(SPEED_RST));
		send_tick(16'd1);
		drain();
		write_reg(REG_FRAME_TIME, 24'd50);
		write_reg(REG_END_HOLD, CFG_DATA_W'($urandom_range(0, 300)));
		write_reg(REG_LOOP_MODE, CFG_DATA_W'(MODE_ONCE));
		repeat (60) send_tick(ELAPSED_W'($urandom_range(0, 400)));

		drain();
		repeat (8) @(posedge clk);
		$display("Covered %0d ticks over %0d register settings in all four modes,", ticks_sent,
			settings);
		$display("with end holds, folded long runs and a play-once run to its last frame.");
		if (fail_count == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
